@@ src/brf_pkg.sv @@
// Package of the byte ring FIFO: widths, codes, the command record passed
// from the front to the back, and the pointer step function.
// No dependencies; every other file of the block depends on it.
package brf_pkg;

  localparam int STORE_DEPTH    = 1024;
  localparam int BYTES_PER_ITEM = 8;

  localparam int PTR_W   = $clog2(STORE_DEPTH);
  localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W   = (BYTES_PER_ITEM > 1) ? $clog2(BYTES_PER_ITEM) : 1;
  localparam int BCNT_W  = 4;
  localparam int CFG_W   = 11;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  typedef logic [7:0]        byte_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [BCNT_W-1:0] bcnt_t;
  typedef logic [1:0]        status_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam status_t ST_PUSHED  = 2'd0;
  localparam status_t ST_DROPPED = 2'd1;
  localparam status_t ST_POPPED  = 2'd2;
  localparam status_t ST_EMPTY   = 2'd3;

  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    CMD_STATUS = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_POP    = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                       kind;
    status_t                         status;
    bcnt_t                           count;
    ptr_t                            start;
    cnt_t                            free;
    logic [BYTES_PER_ITEM-1:0][7:0]  data;
  } cmd_t;

  // Advance a pointer by n slots, wrapping at the capacity in use.
  // The caller guarantees p < cap and n <= cap, so one subtract suffices.
  function automatic ptr_t ptr_step(ptr_t p, cnt_t cap, bcnt_t n);
    cnt_t sum;
    sum = cnt_t'(p) + cnt_t'(n);
    if (sum >= cap) begin
      sum = sum - cap;
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

@@ src/brf_in_if.sv @@
// Input channel of the byte ring FIFO: valid/ready handshake and one item.
// Depends on brf_pkg for the field types.
interface brf_in_if;
  logic           valid;
  logic           ready;
  logic           opcode;
  brf_pkg::bcnt_t byte_count;
  brf_pkg::byte_t byte_0;
  brf_pkg::byte_t byte_1;
  brf_pkg::byte_t byte_2;
  brf_pkg::byte_t byte_3;
  brf_pkg::byte_t byte_4;
  brf_pkg::byte_t byte_5;
  brf_pkg::byte_t byte_6;
  brf_pkg::byte_t byte_7;

  modport source (
    output valid, opcode, byte_count, byte_0, byte_1, byte_2, byte_3,
           byte_4, byte_5, byte_6, byte_7,
    input  ready
  );
  modport sink (
    input  valid, opcode, byte_count, byte_0, byte_1, byte_2, byte_3,
           byte_4, byte_5, byte_6, byte_7,
    output ready
  );
endinterface

@@ src/brf_out_if.sv @@
// Result channel of the byte ring FIFO: valid/ready handshake and one item.
// Depends on brf_pkg for the field types.
interface brf_out_if;
  logic             valid;
  logic             ready;
  brf_pkg::status_t status;
  brf_pkg::byte_t   data_byte;
  logic             last;
  brf_pkg::bcnt_t   moved_count;
  brf_pkg::cnt_t    free_space;

  modport source (
    output valid, status, data_byte, last, moved_count, free_space,
    input  ready
  );
  modport sink (
    input  valid, status, data_byte, last, moved_count, free_space,
    output ready
  );
endinterface

@@ src/brf_front.sv @@
// Front of the byte ring FIFO: accepts items, keeps the fill level and both
// pointers, and turns each item into a command. Depends on brf_pkg, brf_in_if.
module brf_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  brf_pkg::cnt_t cap,
  brf_in_if.sink        in_ch,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output brf_pkg::cmd_t cmd
);
  import brf_pkg::*;

  cnt_t  fill;
  cnt_t  fill_next;
  ptr_t  rd_ptr;
  ptr_t  rd_ptr_next;
  ptr_t  wr_ptr;
  ptr_t  wr_ptr_next;
  cnt_t  free_now;
  cnt_t  cnt_ext;
  bcnt_t pop_n;
  bcnt_t pop_sat;
  logic  drop;
  logic  accept;

  assign in_ch.ready = cmd_ready;
  assign cmd_valid   = in_ch.valid;
  assign accept      = in_ch.valid && cmd_ready;

  assign free_now = cap - fill;
  assign cnt_ext  = cnt_t'(in_ch.byte_count);
  assign drop     = (in_ch.byte_count == '0) ||
                    (in_ch.byte_count > bcnt_t'(BYTES_PER_ITEM)) ||
                    (cnt_ext > free_now);
  assign pop_sat  = (in_ch.byte_count > bcnt_t'(BYTES_PER_ITEM)) ?
                    bcnt_t'(BYTES_PER_ITEM) : in_ch.byte_count;
  assign pop_n    = (cnt_t'(pop_sat) > fill) ? fill[BCNT_W-1:0] : pop_sat;

  always_comb begin
    cmd         = '0;
    cmd.data[0] = in_ch.byte_0;
    cmd.data[1] = in_ch.byte_1;
    cmd.data[2] = in_ch.byte_2;
    cmd.data[3] = in_ch.byte_3;
    cmd.data[4] = in_ch.byte_4;
    cmd.data[5] = in_ch.byte_5;
    cmd.data[6] = in_ch.byte_6;
    cmd.data[7] = in_ch.byte_7;
    fill_next   = fill;
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    if (in_ch.opcode == OP_PUSH) begin
      if (drop) begin
        cmd.kind   = CMD_STATUS;
        cmd.status = ST_DROPPED;
        cmd.free   = free_now;
      end else begin
        cmd.kind    = CMD_PUSH;
        cmd.status  = ST_PUSHED;
        cmd.count   = in_ch.byte_count;
        cmd.start   = wr_ptr;
        cmd.free    = free_now - cnt_ext;
        fill_next   = fill + cnt_ext;
        wr_ptr_next = ptr_step(wr_ptr, cap, in_ch.byte_count);
      end
    end else begin
      if (pop_n == '0) begin
        cmd.kind   = CMD_STATUS;
        cmd.status = ST_EMPTY;
        cmd.free   = free_now;
      end else begin
        cmd.kind    = CMD_POP;
        cmd.status  = ST_POPPED;
        cmd.count   = pop_n;
        cmd.start   = rd_ptr;
        cmd.free    = free_now + cnt_t'(pop_n);
        fill_next   = fill - cnt_t'(pop_n);
        rd_ptr_next = ptr_step(rd_ptr, cap, pop_n);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fill   <= '0;
      rd_ptr <= '0;
      wr_ptr <= '0;
    end else if (accept) begin
      fill   <= fill_next;
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
    end
  end

endmodule

@@ src/brf_cmd_queue.sv @@
// Two-entry command queue between the front and the back of the byte ring
// FIFO, so that each side can stall on its own. Depends on brf_pkg.
module brf_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  brf_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output brf_pkg::cmd_t rd_data
);
  import brf_pkg::*;

  cmd_t       slots [2];
  logic       head;
  logic       tail;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slots[head];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[tail] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) begin
        tail <= ~tail;
      end
      if (do_rd) begin
        head <= ~head;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/brf_back.sv @@
// Back of the byte ring FIFO: owns the byte store, carries out commands one
// byte a cycle (pops only while out_ch is free), drives the result register, depends on brf_pkg, brf_out_if.
module brf_back (
  input  logic          clk,
  input  logic          rst,
  input  brf_pkg::cnt_t cap,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  brf_pkg::cmd_t cmd,
  brf_out_if.source     out_ch
);
  import brf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PUSH = 4'b0010,
    S_STAT = 4'b0100,
    S_POP  = 4'b1000
  } state_t;

  byte_t  mem [STORE_DEPTH];
  byte_t  rdata;
  state_t state;
  cmd_t   cur;
  bcnt_t  idx;
  bcnt_t  idx_inc;
  ptr_t   wr_ptr;
  ptr_t   rd_ptr;
  ptr_t   rd_addr_next;
  logic   out_valid;
  logic   out_free;
  logic   out_load;
  logic   is_last;

  assign out_free     = !out_valid || out_ch.ready;
  assign out_load     = out_free && (state == S_STAT || state == S_POP);
  assign cmd_ready    = (state == S_IDLE);
  assign idx_inc      = idx + bcnt_t'(1);
  assign is_last      = (idx_inc == cur.count);
  assign out_ch.valid = out_valid;

  // The read address moves with the read pointer, so the registered read data
  // always holds the byte at the read pointer from the cycle after a load.
  always_comb begin
    rd_addr_next = rd_ptr;
    if (state == S_IDLE && cmd_valid) begin
      rd_addr_next = cmd.start;
    end else if (state == S_POP && out_free) begin
      rd_addr_next = ptr_step(rd_ptr, cap, bcnt_t'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUSH) begin
      mem[wr_ptr] <= cur.data[idx[IDX_W-1:0]];
    end
    rdata <= mem[rd_addr_next];
  end

  always_ff @(posedge clk) begin
    rd_ptr <= rd_addr_next;
    case (state)
      S_IDLE: begin
        cur    <= cmd;
        idx    <= '0;
        wr_ptr <= cmd.start;
      end
      S_PUSH: begin
        wr_ptr <= ptr_step(wr_ptr, cap, bcnt_t'(1));
        idx    <= idx_inc;
      end
      S_POP: begin
        if (out_free) begin
          idx <= idx_inc;
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ch.ready);
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.kind)
              CMD_PUSH: state <= S_PUSH;
              CMD_POP:  state <= S_POP;
              default:  state <= S_STAT;
            endcase
          end
        end
        S_PUSH: begin
          if (is_last) begin
            state <= S_STAT;
          end
        end
        S_STAT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_POP: begin
          if (out_free && is_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state == S_STAT) begin
        out_ch.status      <= cur.status;
        out_ch.data_byte   <= '0;
        out_ch.last        <= 1'b1;
        out_ch.moved_count <= cur.count;
        out_ch.free_space  <= cur.free;
      end else if (state == S_POP) begin
        out_ch.status      <= ST_POPPED;
        out_ch.data_byte   <= rdata;
        out_ch.last        <= is_last;
        out_ch.moved_count <= cur.count;
        out_ch.free_space  <= cur.free;
      end
    end
  end

endmodule

@@ src/byte_ring_fifo_block_push_pop.sv @@
// Top level of the byte ring FIFO: configuration register, front, command
// queue and back. Depends on brf_pkg, brf_in_if, brf_out_if and all brf_ modules.
//
// Usage. Items enter on in_ch with a valid/ready handshake. A push item
// (opcode 0) carries byte_count bytes in byte_0 (oldest) through byte_7; it
// is stored whole when it has 1 to 8 bytes that all fit, dropped whole otherwise,
// and either way one status item comes out on out_ch. A pop item (opcode 1)
// asks for byte_count bytes; it yields one item per stored byte, up to eight,
// with last set on the final one, or a single empty status when nothing can
// be moved. Every result carries the item's moved count and the free space
// left after it.
// The capacity register, at APB byte address 0, sets how many store slots
// are in use (0 acts as 1, values above 1024 act as 1024). Any write to it
// empties the FIFO; write it only while the block is idle.
// Flow. The front classifies an item in its accept cycle and hands a
// command to a two-entry queue. The back runs one command at a time out of
// the 1024-byte store: a push has a load step, one write per byte and a
// status step; a pop has a load step and then one result per byte; a
// status-only item has a load step and a status step. An accepted item is
// registered in the queue and loaded by the back, and its result is
// registered in the result register before it shows on out_ch. If out_ch
// stalls, the result register holds, the back waits and the queue fills;
// in_ch.ready falls once the queue is full. Reset empties the FIFO, clears
// the queue and the result valid, and sets the capacity to 1024.
module byte_ring_fifo_block_push_pop (
  input  logic                        clk,
  input  logic                        rst,
  brf_in_if.sink                      in_ch,
  brf_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [brf_pkg::APB_AW-1:0]  paddr,
  input  logic [brf_pkg::APB_DW-1:0]  pwdata,
  output logic [brf_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import brf_pkg::*;

  logic [CFG_W-1:0] cap_reg;
  cnt_t             cap_eff;
  logic             cfg_write;
  logic             q_wr_valid;
  logic             q_wr_ready;
  cmd_t             q_wr_data;
  logic             q_rd_valid;
  logic             q_rd_ready;
  cmd_t             q_rd_data;

  // The APB port never waits. Register index is taken from address bit 2;
  // writes to any other index are ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CFG_W'(STORE_DEPTH);
    end else if (cfg_write) begin
      cap_reg <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(cap_reg) : '0;

  // Effective capacity: zero is treated as one slot, anything above the
  // store depth as the full store.
  always_comb begin
    if (cap_reg == '0) begin
      cap_eff = cnt_t'(1);
    end else if (cap_reg > CFG_W'(STORE_DEPTH)) begin
      cap_eff = cnt_t'(STORE_DEPTH);
    end else begin
      cap_eff = cnt_t'(cap_reg);
    end
  end

  brf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_write),
    .cap       (cap_eff),
    .in_ch     (in_ch),
    .cmd_valid (q_wr_valid),
    .cmd_ready (q_wr_ready),
    .cmd       (q_wr_data)
  );

  brf_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rd_data)
  );

  brf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cap       (cap_eff),
    .cmd_valid (q_rd_valid),
    .cmd_ready (q_rd_ready),
    .cmd       (q_rd_data),
    .out_ch    (out_ch)
  );

endmodule

@@ verif/byte_ring_fifo_block_push_pop_tb.sv @@
// Self-checking testbench for the byte ring FIFO with block push and pop items.
// Depends on brf_pkg, brf_in_if, brf_out_if and the byte_ring_fifo_block_push_pop RTL.
// It predicts every result in SystemVerilog and checks it field by field.
module byte_ring_fifo_block_push_pop_tb;
  import brf_pkg::*;

  // The capacity register sits at byte address 0, as register index 0.
  localparam logic [APB_AW-1:0] CAP_ADDR = APB_AW'(4 * REG_CAPACITY);

  // The longest stretch without any handshake in a correct run is a sender gap,
  // a receiver stall, a drain pause or a register access. The limit is set
  // far above that.
  localparam int WATCHDOG_LIMIT = 1000;

  // Quiet cycles waited after the last expected result has arrived, so that
  // the back end settles before a register access or the end of the run.
  localparam int DRAIN_CYCLES = 16;

  localparam int ITEMS_PER_PHASE = 20;
  localparam int MAX_REPORTS     = 50;

  // One expected result, at the widths of the result channel.
  typedef struct packed {
    status_t status;
    byte_t   data_byte;
    logic    last;
    bcnt_t   moved_count;
    cnt_t    free_space;
  } fifo_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  brf_in_if  in_ch ();
  brf_out_if out_ch ();

  byte_ring_fifo_block_push_pop dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the ring: the raw capacity register, the byte store, both
  // pointers and the fill level, updated at each accepted item or write.
  logic [CFG_W-1:0] cap_reg;
  byte_t            ring_store [STORE_DEPTH];
  int unsigned      rd_ptr;
  int unsigned      wr_ptr;
  int unsigned      fill;

  fifo_result_t pending_results [$];
  fifo_result_t want;
  int unsigned  error_count;
  int unsigned  result_idx;
  int unsigned  idle_cycles;

  // The clock toggles every half period of 5 time units.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Every failure goes through here: one line each, and the count decides
  // the final verdict. Printing stops after a while so a broken block cannot
  // flood the log, but counting goes on.
  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endtask

  function automatic void push_result(input status_t st, input byte_t data_val,
                                      input logic last_val, input int unsigned moved,
                                      input int unsigned free_val);
    fifo_result_t r;
    r.status      = st;
    r.data_byte   = data_val;
    r.last        = last_val;
    r.moved_count = bcnt_t'(moved);
    r.free_space  = cnt_t'(free_val);
    pending_results.push_back(r);
  endfunction

  // Works out the results of one accepted item and advances the shadow ring.
  // Push bytes go in oldest first from payload[0]; pointers wrap at the
  // capacity in use, where a register value of 0 acts as 1 and anything above
  // the store depth acts as the store depth.
  function automatic void predict_fifo_item(input logic op, input bcnt_t cnt,
                                            input logic [7:0][7:0] payload);
    int unsigned cap;
    int unsigned n;
    int unsigned freesp;
    byte_t       b;
    cap = (cap_reg == 0) ? 1 : ((cap_reg > STORE_DEPTH) ? STORE_DEPTH : cap_reg);
    if (rd_ptr >= cap) rd_ptr = 0;
    if (wr_ptr >= cap) wr_ptr = 0;
    if (fill > cap) fill = cap;
    if (op == OP_PUSH) begin
      freesp = cap - fill;
      // A push is taken whole or dropped whole; a zero count or one above
      // the item width is dropped as well.
      if (cnt == 0 || cnt > BYTES_PER_ITEM || cnt > freesp) begin
        push_result(ST_DROPPED, 8'h00, 1'b1, 0, freesp);
      end else begin
        for (int i = 0; i < cnt; i++) begin
          ring_store[wr_ptr] = payload[i];
          wr_ptr = (wr_ptr + 1 >= cap) ? 0 : wr_ptr + 1;
        end
        fill += cnt;
        push_result(ST_PUSHED, 8'h00, 1'b1, cnt, cap - fill);
      end
    end else begin
      // A pop saturates at the item width and at what is stored.
      n = cnt;
      if (n > BYTES_PER_ITEM) n = BYTES_PER_ITEM;
      if (n > fill) n = fill;
      if (n == 0) begin
        push_result(ST_EMPTY, 8'h00, 1'b1, 0, cap - fill);
      end else begin
        fill -= n;
        for (int i = 0; i < n; i++) begin
          b = ring_store[rd_ptr];
          rd_ptr = (rd_ptr + 1 >= cap) ? 0 : rd_ptr + 1;
          push_result(ST_POPPED, b, (i + 1 == n), n, cap - fill);
        end
      end
    end
  endfunction

  function automatic logic [7:0][7:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  // Sends one item. It starts and ends at a falling edge; valid is left high
  // so that a following call continues the burst without a bubble.
  task automatic send_item(input logic op, input bcnt_t cnt,
                           input logic [7:0][7:0] payload);
    in_ch.valid      = 1'b1;
    in_ch.opcode     = op;
    in_ch.byte_count = cnt;
    in_ch.byte_0     = payload[0];
    in_ch.byte_1     = payload[1];
    in_ch.byte_2     = payload[2];
    in_ch.byte_3     = payload[3];
    in_ch.byte_4     = payload[4];
    in_ch.byte_5     = payload[5];
    in_ch.byte_6     = payload[6];
    in_ch.byte_7     = payload[7];
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predict_fifo_item(op, cnt, payload);
    @(negedge clk);
  endtask

  // Lowers valid for a gap of length n; a zero gap keeps the burst going.
  task automatic idle_gap(input int unsigned n);
    if (n > 0) begin
      in_ch.valid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Stops sending until every expected result has arrived, then lets the
  // back end settle. Register accesses and the end of the run rely on this.
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes the capacity register with a setup and an access cycle. The write
  // also empties the ring, so the shadow pointers go back to zero.
  task automatic write_capacity(input logic [CFG_W-1:0] value);
    wait_drained();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CAP_ADDR;
    pwdata  = APB_DW'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    cap_reg = value;
    rd_ptr  = 0;
    wr_ptr  = 0;
    fill    = 0;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Reads the capacity register back and compares it with the raw value
  // last written.
  task automatic check_capacity_readback();
    wait_drained();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = CAP_ADDR;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata !== APB_DW'(cap_reg)) begin
      report_error($sformatf("capacity read expected %0d got %0d", cap_reg, prdata));
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Directed item with a short random gap after it.
  task automatic directed_item(input logic op, input bcnt_t cnt);
    send_item(op, cnt, rand_payload());
    idle_gap($urandom_range(0, 2));
  endtask

  // After reset the capacity is the whole store. This covers pop on empty,
  // a full-width push and pop, zero counts for both operations, a push count
  // above the item width and a pop count that saturates at the item width.
  task automatic test_reset_defaults();
    check_capacity_readback();
    directed_item(OP_POP, 4'd1);
    directed_item(OP_PUSH, 4'd8);
    directed_item(OP_PUSH, 4'd0);
    directed_item(OP_PUSH, 4'd15);
    directed_item(OP_POP, 4'd0);
    directed_item(OP_POP, 4'd15);
    directed_item(OP_POP, 4'd3);
  endtask

  // A capacity of zero acts as one slot: one byte fits, the next push is
  // dropped as full, and a larger pop returns only the stored byte. A value
  // with every bit set acts as the full store.
  task automatic test_capacity_clamp();
    write_capacity(11'd0);
    check_capacity_readback();
    directed_item(OP_PUSH, 4'd1);
    directed_item(OP_PUSH, 4'd1);
    directed_item(OP_POP, 4'd3);
    directed_item(OP_POP, 4'd1);
    write_capacity(11'h7ff);
    check_capacity_readback();
    directed_item(OP_PUSH, 4'd8);
    directed_item(OP_POP, 4'd8);
  endtask

  // With five slots the pointers wrap inside a single push, the ring fills
  // so a push is dropped for lack of space, and a large pop drains it.
  task automatic test_wrap_and_full();
    write_capacity(11'd5);
    directed_item(OP_PUSH, 4'd3);
    directed_item(OP_POP, 4'd2);
    directed_item(OP_PUSH, 4'd4);
    directed_item(OP_PUSH, 4'd1);
    directed_item(OP_POP, 4'd8);
    directed_item(OP_POP, 4'd2);
  endtask

  // Random traffic over several capacities, the extremes among them. Most
  // counts are in range so the ring fills and drains; the rest are zero or
  // above the item width. Halfway through each phase the sender holds off
  // until the result channel has caught up.
  task automatic test_random_traffic();
    logic [CFG_W-1:0] caps [5];
    int unsigned      sent;
    int unsigned      burst;
    int unsigned      push_pct;
    logic             op;
    bcnt_t            cnt;
    caps[0] = CFG_W'($urandom_range(2, 12));
    caps[1] = CFG_W'(STORE_DEPTH);
    caps[2] = 11'd1;
    caps[3] = CFG_W'($urandom_range(13, 40));
    caps[4] = CFG_W'($urandom_range(41, STORE_DEPTH - 1));
    for (int ph = 0; ph < 5; ph++) begin
      write_capacity(caps[ph]);
      // Large rings need more pushes than pops to get anywhere near full.
      push_pct = (caps[ph] > 64) ? 70 : 50;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst && sent < ITEMS_PER_PHASE; b++) begin
          if (sent == ITEMS_PER_PHASE / 2) begin
            wait_drained();
          end
          op = ($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_POP;
          if ($urandom_range(0, 6) == 0) begin
            cnt = ($urandom_range(0, 3) == 0) ? 4'd0 : bcnt_t'($urandom_range(9, 15));
          end else begin
            cnt = bcnt_t'($urandom_range(1, BYTES_PER_ITEM));
          end
          send_item(op, cnt, rand_payload());
          sent++;
        end
        idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
      end
    end
  endtask

  // The receiver switches at random between three behaviors: always ready,
  // ready with a chance of three in four, or mostly ready with random
  // stalls. Ready changes only at the falling edge.
  initial begin : result_receiver
    int unsigned stall_mode;
    int unsigned mode_left;
    int unsigned stall_left;
    mode_left    = 0;
    stall_left   = 0;
    stall_mode   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 80);
      end
      mode_left--;
      case (stall_mode)
        0: begin
          out_ch.ready = 1'b1;
        end
        1: begin
          out_ch.ready = ($urandom_range(0, 3) != 0);
        end
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ch.ready = 1'b0;
          end else if ($urandom_range(0, 5) == 0) begin
            stall_left   = $urandom_range(1, 7);
            out_ch.ready = 1'b0;
          end else begin
            out_ch.ready = 1'b1;
          end
        end
      endcase
    end
  end

  // Each accepted result is matched against the oldest expectation. The
  // comparisons use the four-state operator so an unknown field fails too.
  always @(posedge clk) begin
    if (rst === 1'b0 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected, status %0d",
                               result_idx, out_ch.status));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          report_error($sformatf("result %0d status expected %0d got %0d",
                                 result_idx, want.status, out_ch.status));
        end
        if (out_ch.data_byte !== want.data_byte) begin
          report_error($sformatf("result %0d data_byte expected %0d got %0d",
                                 result_idx, want.data_byte, out_ch.data_byte));
        end
        if (out_ch.last !== want.last) begin
          report_error($sformatf("result %0d last expected %0d got %0d",
                                 result_idx, want.last, out_ch.last));
        end
        if (out_ch.moved_count !== want.moved_count) begin
          report_error($sformatf("result %0d moved_count expected %0d got %0d",
                                 result_idx, want.moved_count, out_ch.moved_count));
        end
        if (out_ch.free_space !== want.free_space) begin
          report_error($sformatf("result %0d free_space expected %0d got %0d",
                                 result_idx, want.free_space, out_ch.free_space));
        end
      end
      result_idx++;
    end
  end

  // The watchdog counts cycles in which no handshake of any kind completes.
  // A hung block, a lost result or a stuck ready all end up here.
  always @(posedge clk) begin
    if (rst === 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (psel === 1'b1 && penable === 1'b1 && pready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("byte_ring_fifo_block_push_pop: mismatch");
      $finish;
    end
  end

  // Main sequence: drive every input to a known value, hold reset,
  // run each test in turn, then drain and give the verdict.
  initial begin
    error_count      = 0;
    result_idx       = 0;
    idle_cycles      = 0;
    cap_reg          = CFG_W'(STORE_DEPTH);
    rd_ptr           = 0;
    wr_ptr           = 0;
    fill             = 0;
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_PUSH;
    in_ch.byte_count = '0;
    in_ch.byte_0     = '0;
    in_ch.byte_1     = '0;
    in_ch.byte_2     = '0;
    in_ch.byte_3     = '0;
    in_ch.byte_4     = '0;
    in_ch.byte_5     = '0;
    in_ch.byte_6     = '0;
    in_ch.byte_7     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_capacity_clamp();
    test_wrap_and_full();
    test_random_traffic();

    wait_drained();
    if (error_count == 0) begin
      $display("byte_ring_fifo_block_push_pop: match");
    end else begin
      $display("byte_ring_fifo_block_push_pop: mismatch");
    end
    $finish;
  end

endmodule
